### design/tte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    // input command codes
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // opcode values in the second opcode byte
    localparam logic [7:0] OPC_RRQ   = 8'd1;
    localparam logic [7:0] OPC_WRQ   = 8'd2;
    localparam logic [7:0] OPC_DATA  = 8'd3;
    localparam logic [7:0] OPC_ACK   = 8'd4;
    localparam logic [7:0] OPC_ERROR = 8'd5;

    // send_kind codes
    localparam logic [1:0] SEND_NONE  = 2'd0;
    localparam logic [1:0] SEND_ACK   = 2'd1;
    localparam logic [1:0] SEND_DATA  = 2'd2;
    localparam logic [1:0] SEND_ERROR = 2'd3;

    // write_finished codes
    localparam logic [1:0] WF_NONE     = 2'd0;
    localparam logic [1:0] WF_EXACT    = 2'd1;
    localparam logic [1:0] WF_MISMATCH = 2'd2;

    // session_end codes
    localparam logic [1:0] END_NONE       = 2'd0;
    localparam logic [1:0] END_READ_DONE  = 2'd1;
    localparam logic [1:0] END_PEER_ERROR = 2'd2;
    localparam logic [1:0] END_RETRIES    = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERROR,
        OP_TICK,
        OP_RRQ,
        OP_WRQ,
        OP_DATA,
        OP_ACK,
        OP_PEER_ERR
    } op_t;

    typedef enum logic [1:0] {
        LS_IDLE,
        LS_ACK,
        LS_DATA
    } last_t;

    // classified word handed from front to back
    typedef struct packed {
        op_t         op;
        logic [15:0] block;
        logic [15:0] file_len;
        logic        short_pkt;
        logic        header_only;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] send_block;
        logic [9:0]  send_data_len;
        logic        store_block;
        logic        page_full;
        logic        enter_transfer;
        logic [1:0]  write_finished;
        logic [1:0]  session_end;
    } result_t;

endpackage

`default_nettype wire

### design/tte_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tte_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        socket_match;
    logic        in_standby;
    logic        in_transfer_mode;
    logic [7:0]  opcode_high;
    logic [7:0]  opcode_low;
    logic [15:0] block_number;
    logic [15:0] packet_length;
    logic [15:0] file_length;

    modport source (
        output valid, cmd, socket_match, in_standby, in_transfer_mode,
               opcode_high, opcode_low, block_number, packet_length, file_length,
        input  ready
    );

    modport sink (
        input  valid, cmd, socket_match, in_standby, in_transfer_mode,
               opcode_high, opcode_low, block_number, packet_length, file_length,
        output ready
    );
endinterface

`default_nettype wire

### design/tte_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tte_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  send_kind;
    logic [15:0] send_block;
    logic [9:0]  send_data_len;
    logic        store_block;
    logic        page_full;
    logic        enter_transfer;
    logic [1:0]  write_finished;
    logic [1:0]  session_end;

    modport source (
        output valid, send_kind, send_block, send_data_len, store_block, page_full,
               enter_transfer, write_finished, session_end,
        input  ready
    );

    modport sink (
        input  valid, send_kind, send_block, send_data_len, store_block, page_full,
               enter_transfer, write_finished, session_end,
        output ready
    );
endinterface

`default_nettype wire

### design/tftp_transfer_engine.sv
// TFTP transfer engine: serves one read or write transfer at a time.
// Channel hdr (sink): one word per received packet header or timer tick
//   (cmd, socket, mode bits, opcode bytes, block number, lengths).
// Channel action (source): one word per input word saying what to send
//   (nothing, ACK, DATA with payload length, ERROR), plus store, page,
//   transfer-entry, write-done and session-end flags.
// Both channels move a word on a clock edge with valid and ready high.
// The front classifies each header and pushes it into a 4-entry queue;
// the back pops one word a cycle while the output register is free or
// being drained, updates the transfer state and loads the output
// register. An accepted word is written into its queue slot and is then
// popped from there into the output register.
// When action stalls the output register holds its word, the back stops
// popping and the queue fills; hdr.ready drops once four words wait.
// Reset (rst_n low, asynchronous) empties the queue and output and
// clears block number, byte counts, retry and tick counters.
`timescale 1ns / 1ps
`default_nettype none

module tftp_transfer_engine #(
    parameter int BLOCK_BYTES = 512,
    parameter int MAX_RETRIES = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    tte_in_if.sink    hdr,
    tte_out_if.source action
);
    import tte_pkg::*;

    logic full;
    logic empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head;

    tte_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .hdr  (hdr),
        .full (full),
        .push (push),
        .cmd  (push_cmd)
    );

    tte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    tte_exec #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_RETRIES (MAX_RETRIES)
    ) u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .cmd    (head),
        .pop    (pop),
        .action (action)
    );

endmodule

`default_nettype wire

### design/tte_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tte_front #(
    parameter int BLOCK_BYTES = 512
) (
    tte_in_if.sink        hdr,
    input  logic          full,
    output logic          push,
    output tte_pkg::cmd_t cmd
);
    import tte_pkg::*;

    localparam logic [16:0] SHORT_LIMIT = 17'(BLOCK_BYTES) + 17'd4;

    assign hdr.ready = !full;
    assign push      = hdr.valid && !full;

    always_comb
    begin
        cmd.block       = hdr.block_number;
        cmd.file_len    = hdr.file_length;
        cmd.short_pkt   = {1'b0, hdr.packet_length} < SHORT_LIMIT;
        cmd.header_only = hdr.packet_length == 16'd4;
        cmd.op          = OP_NONE;
        priority if (hdr.cmd == CMD_TICK)
        begin
            // ticks count only while a transfer is running
            cmd.op = hdr.in_transfer_mode ? OP_TICK : OP_NONE;
        end
        else if ((!hdr.in_standby && !hdr.in_transfer_mode) || !hdr.socket_match)
        begin
            cmd.op = OP_NONE;
        end
        else if (hdr.opcode_high != 8'd0)
        begin
            cmd.op = OP_ERROR;
        end
        else
        begin
            unique case (hdr.opcode_low)
                OPC_RRQ:   cmd.op = OP_RRQ;
                OPC_WRQ:   cmd.op = OP_WRQ;
                OPC_DATA:  cmd.op = OP_DATA;
                OPC_ACK:   cmd.op = OP_ACK;
                OPC_ERROR: cmd.op = OP_PEER_ERR;
                default:   cmd.op = OP_ERROR;
            endcase
        end
    end

endmodule

`default_nettype wire

### design/tte_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tte_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tte_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output tte_pkg::cmd_t head
);
    import tte_pkg::*;

    localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = count_reg == DEPTH_CNT;
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue occupancy beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue occupancy did not grow on push");

endmodule

`default_nettype wire

### design/tte_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module tte_exec #(
    parameter int BLOCK_BYTES = 512,
    parameter int MAX_RETRIES = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  tte_pkg::cmd_t cmd,
    output logic          pop,
    tte_out_if.source     action
);
    import tte_pkg::*;

    localparam logic [15:0] BLK16       = 16'(BLOCK_BYTES);
    localparam logic [2:0]  RETRY_LIMIT = 3'(MAX_RETRIES);

    logic [15:0] expected_block_reg, expected_block_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] file_size_reg, file_size_next;
    logic        read_complete_reg, read_complete_next;
    last_t       last_sent_reg, last_sent_next;
    logic [3:0]  tick_count_reg, tick_count_next;
    logic [2:0]  retry_count_reg, retry_count_next;
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg;
    result_t     res;

    logic [3:0]  tick_inc;
    logic [7:0]  wait_ticks;
    logic        timeout;
    logic [2:0]  retry_inc;
    logic [15:0] exp_inc;
    logic [15:0] bc_sum;
    logic [15:0] bc_dec;
    logic        rc_dec;
    logic        block_hit;

    function automatic logic full_left(input logic [15:0] bc, input logic rc);
        return (bc == 16'd0 && !rc) || bc >= BLK16;
    endfunction

    function automatic logic [9:0] data_len(input logic [15:0] bc, input logic rc);
        logic [15:0] len;
        len = full_left(bc, rc) ? BLK16 : bc;
        return len[9:0];
    endfunction

    // take the next word whenever the output register is free or being drained
    assign pop = !empty && (!out_valid_reg || action.ready);

    assign tick_inc   = (tick_count_reg != 4'hF) ? tick_count_reg + 4'd1 : tick_count_reg;
    assign wait_ticks = 8'd1 << retry_count_reg;
    assign timeout    = ({4'd0, tick_inc} > wait_ticks) || tick_inc == 4'hF;
    assign retry_inc  = retry_count_reg + 3'd1;
    assign exp_inc    = expected_block_reg + 16'd1;
    assign bc_sum     = byte_count_reg + BLK16;
    assign bc_dec     = byte_count_reg - BLK16;
    assign rc_dec     = read_complete_reg || (bc_dec < BLK16);
    assign block_hit  = expected_block_reg == cmd.block;

    always_comb
    begin
        expected_block_next = expected_block_reg;
        byte_count_next     = byte_count_reg;
        file_size_next      = file_size_reg;
        read_complete_next  = read_complete_reg;
        last_sent_next      = last_sent_reg;
        tick_count_next     = tick_count_reg;
        retry_count_next    = retry_count_reg;
        res                 = '0;

        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_ERROR:
            begin
                res.send_kind = SEND_ERROR;
            end
            OP_TICK:
            begin
                if (timeout)
                begin
                    tick_count_next = 4'd0;
                    if (retry_inc >= RETRY_LIMIT)
                    begin
                        res.session_end     = END_RETRIES;
                        expected_block_next = 16'd0;
                        retry_count_next    = 3'd0;
                        last_sent_next      = LS_IDLE;
                    end
                    else
                    begin
                        retry_count_next = retry_inc;
                        if (last_sent_reg == LS_ACK)
                        begin
                            // resend the last ACK
                            res.send_kind  = SEND_ACK;
                            res.send_block = expected_block_reg - 16'd1;
                        end
                        else if (last_sent_reg == LS_DATA)
                        begin
                            res.send_kind     = SEND_DATA;
                            res.send_block    = expected_block_reg;
                            res.send_data_len = data_len(byte_count_reg, read_complete_reg);
                        end
                    end
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            OP_DATA:
            begin
                if (block_hit)
                begin
                    expected_block_next = exp_inc;
                    retry_count_next    = 3'd0;
                    if (cmd.short_pkt)
                    begin
                        res.write_finished = (byte_count_reg == file_size_reg
                                              && cmd.header_only) ? WF_EXACT : WF_MISMATCH;
                        res.send_kind      = SEND_ACK;
                        res.send_block     = cmd.block;
                        tick_count_next    = 4'd0;
                        last_sent_next     = LS_ACK;
                    end
                    else
                    begin
                        res.store_block = 1'b1;
                        byte_count_next = bc_sum;
                        res.page_full   = bc_sum == file_size_reg;
                        // a wrap of the block number to zero is not acknowledged
                        if (cmd.block <= exp_inc)
                        begin
                            res.send_kind   = SEND_ACK;
                            res.send_block  = cmd.block;
                            tick_count_next = 4'd0;
                            last_sent_next  = LS_ACK;
                        end
                    end
                end
                else if (cmd.block <= expected_block_reg)
                begin
                    res.send_kind   = SEND_ACK;
                    res.send_block  = cmd.block;
                    tick_count_next = 4'd0;
                    last_sent_next  = LS_ACK;
                end
            end
            OP_ACK:
            begin
                if (block_hit)
                begin
                    if (full_left(byte_count_reg, read_complete_reg))
                    begin
                        byte_count_next     = bc_dec;
                        read_complete_next  = rc_dec;
                        expected_block_next = exp_inc;
                        retry_count_next    = 3'd0;
                        res.send_kind       = SEND_DATA;
                        res.send_block      = exp_inc;
                        res.send_data_len   = data_len(bc_dec, rc_dec);
                        tick_count_next     = 4'd0;
                        last_sent_next      = LS_DATA;
                    end
                    else
                    begin
                        res.session_end     = END_READ_DONE;
                        expected_block_next = 16'd0;
                        tick_count_next     = 4'd0;
                        retry_count_next    = 3'd0;
                        last_sent_next      = LS_IDLE;
                    end
                end
            end
            OP_RRQ:
            begin
                res.enter_transfer  = 1'b1;
                byte_count_next     = cmd.file_len;
                expected_block_next = 16'd1;
                read_complete_next  = 1'b0;
                retry_count_next    = 3'd0;
                res.send_kind       = SEND_DATA;
                res.send_block      = 16'd1;
                res.send_data_len   = data_len(cmd.file_len, 1'b0);
                tick_count_next     = 4'd0;
                last_sent_next      = LS_DATA;
            end
            OP_WRQ:
            begin
                res.enter_transfer  = 1'b1;
                expected_block_next = 16'd1;
                retry_count_next    = 3'd0;
                byte_count_next     = 16'd0;
                file_size_next      = cmd.file_len;
                res.send_kind       = SEND_ACK;
                res.send_block      = 16'd0;
                tick_count_next     = 4'd0;
                last_sent_next      = LS_ACK;
            end
            OP_PEER_ERR:
            begin
                res.session_end     = END_PEER_ERROR;
                expected_block_next = 16'd0;
                tick_count_next     = 4'd0;
                retry_count_next    = 3'd0;
                last_sent_next      = LS_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (action.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_block_reg <= 16'd0;
            byte_count_reg     <= 16'd0;
            file_size_reg      <= 16'd0;
            read_complete_reg  <= 1'b0;
            last_sent_reg      <= LS_IDLE;
            tick_count_reg     <= 4'd0;
            retry_count_reg    <= 3'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                expected_block_reg <= expected_block_next;
                byte_count_reg     <= byte_count_next;
                file_size_reg      <= file_size_next;
                read_complete_reg  <= read_complete_next;
                last_sent_reg      <= last_sent_next;
                tick_count_reg     <= tick_count_next;
                retry_count_reg    <= retry_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= res;
        end
    end

    assign action.valid          = out_valid_reg;
    assign action.send_kind      = result_reg.send_kind;
    assign action.send_block     = result_reg.send_block;
    assign action.send_data_len  = result_reg.send_data_len;
    assign action.store_block    = result_reg.store_block;
    assign action.page_full      = result_reg.page_full;
    assign action.enter_transfer = result_reg.enter_transfer;
    assign action.write_finished = result_reg.write_finished;
    assign action.session_end    = result_reg.session_end;

    a_retry_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        retry_count_reg < RETRY_LIMIT)
        else $error("retry count reached the abandon limit");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res.session_end != END_NONE)
        |=> (expected_block_reg == 16'd0 && last_sent_reg == LS_IDLE
             && retry_count_reg == 3'd0))
        else $error("session end left transfer state behind");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !action.ready) |-> !pop)
        else $error("held result overwritten");

endmodule

`default_nettype wire
